### rtl/pse_pkg.sv
// Shared types, constants and the byte classifier of the postfix evaluator.
// No dependencies; all files but pse_ram refer to it by scoped names.
`default_nettype none

package pse_pkg;

   // Stack sizing
   localparam int STACK_DEPTH = 128;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   // Queue between classifier and stack engine (power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DATA_W = 32;

   // Character codes
   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_UP_A  = 8'd65;
   localparam logic [7:0] CHAR_UP_Z  = 8'd90;
   localparam logic [7:0] CHAR_LO_A  = 8'd97;
   localparam logic [7:0] CHAR_LO_Z  = 8'd122;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_STAR  = 8'd42;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_UNDER = 2'd1,
      ERR_OVER  = 2'd2,
      ERR_DIV0  = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      KIND_PUSH,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] value;   // operand value, byte minus '0'
   } item_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

   function automatic item_type classify(input logic [7:0] ch);
      item_type   it;
      logic [7:0] diff;
      diff     = ch - CHAR_ZERO;
      it.value = diff[6:0];
      if (ch == CHAR_NUL) begin
         it.kind = KIND_END;
      end else if ((ch >= CHAR_ZERO && ch <= CHAR_NINE) ||
                   (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) ||
                   (ch >= CHAR_LO_A && ch <= CHAR_LO_Z)) begin
         it.kind = KIND_PUSH;
      end else if (ch == CHAR_PLUS) begin
         it.kind = KIND_ADD;
      end else if (ch == CHAR_MINUS) begin
         it.kind = KIND_SUB;
      end else if (ch == CHAR_STAR) begin
         it.kind = KIND_MUL;
      end else begin
         it.kind = KIND_DIV;
      end
      return it;
   endfunction

endpackage

`default_nettype wire

### rtl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/pse_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pse_pkg for the request/response structs.
`default_nettype none

module pse_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pse_pkg::div_req_type req,
   output pse_pkg::div_rsp_type      rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;

   logic [32:0] shifted;
   logic [32:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = 5'd31;
         rem_in  = '0;
         quo_in  = req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
         den_in  = req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
         neg_in  = req.dividend[31] ^ req.divisor[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   // magnitude 2^31 with a positive sign wraps to the most negative value
   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? (~quo_ff + 32'd1) : quo_ff;

endmodule

`default_nettype wire

### rtl/pse_front.sv
// Front end: classifies incoming expression bytes and queues them.
// Depends on pse_pkg for the item type and classifier.
`default_nettype none

module pse_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] char_in
   output logic                   deq_valid,
   input  wire logic              deq_ready,
   output pse_pkg::item_type      deq_item
);

   pse_pkg::item_type q_ff [pse_pkg::QUEUE_DEPTH];

   logic [pse_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pse_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pse_pkg::QCNT_W-1:0] fill_ff, fill_in;
   logic                       push;
   logic                       pop;

   assign req_tready = (fill_ff != pse_pkg::QCNT_W'(pse_pkg::QUEUE_DEPTH));
   assign deq_valid  = (fill_ff != '0);
   assign deq_item   = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = deq_valid && deq_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= pse_pkg::classify(req_tdata);
      end
   end

endmodule

`default_nettype wire

### rtl/pse_back.sv
// Back end: operand stack engine with top-of-stack register, stack RAM,
// divider and the result register. Depends on pse_pkg, pse_ram and pse_div.
`default_nettype none

module pse_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              deq_valid,
   output logic                   deq_ready,
   input  wire pse_pkg::item_type deq_item,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata,
   output logic                   rsp_tlast,
   output logic [1:0]             rsp_tuser
);

   typedef enum logic [1:0] {
      S_FETCH,
      S_READ,
      S_DIV,
      S_PUSH
   } state_type;

   state_type                   state_ff, state_in;
   logic [pse_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   pse_pkg::err_type            err_ff, err_in;
   pse_pkg::kind_type           kind_ff, kind_in;
   logic [31:0]                 top_ff, top_in;
   logic [31:0]                 res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_value_ff, rsp_value_in;
   pse_pkg::err_type            rsp_status_ff, rsp_status_in;
   logic                        rsp_done_ff, rsp_done_in;

   logic                        out_free;
   logic [31:0]                 top_view;
   logic [pse_pkg::CNT_W-1:0]   cnt_m1;
   logic [pse_pkg::CNT_W-1:0]   cnt_m2;
   logic                        ram_we;
   logic                        ram_re;
   logic [31:0]                 ram_rd;
   logic [31:0]                 push_val;
   pse_pkg::div_req_type        div_req;
   pse_pkg::div_rsp_type        div_rsp;

   function automatic pse_pkg::err_type flag(input pse_pkg::err_type cur,
                                             input pse_pkg::err_type code);
      return (cur == pse_pkg::ERR_NONE) ? code : cur;
   endfunction

   pse_ram #(
      .WIDTH (32),
      .DEPTH (pse_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_m1[pse_pkg::ADDR_W-1:0]),
      .wr_data (top_ff),
      .rd_en   (ram_re),
      .rd_addr (cnt_m2[pse_pkg::ADDR_W-1:0]),
      .rd_data (ram_rd)
   );

   pse_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign deq_ready = (state_ff == S_FETCH) && out_free;
   assign top_view  = (cnt_ff == '0) ? 32'd0 : top_ff;
   assign cnt_m1    = cnt_ff - 1'b1;
   assign cnt_m2    = cnt_ff - 2'd2;
   assign push_val  = {25'd0, deq_item.value};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      kind_in       = kind_ff;
      top_in        = top_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      div_req       = '0;
      div_req.dividend = ram_rd;
      div_req.divisor  = top_ff;

      unique case (state_ff)
         S_FETCH: begin
            if (deq_valid && out_free) begin
               kind_in      = deq_item.kind;
               rsp_done_in  = 1'b0;
               case (deq_item.kind)
                  pse_pkg::KIND_END: begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = top_view;
                     rsp_status_in = err_ff;
                     rsp_done_in   = 1'b1;
                     cnt_in        = '0;
                     err_in        = pse_pkg::ERR_NONE;
                  end
                  pse_pkg::KIND_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_ff >= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH)) begin
                        err_in        = flag(err_ff, pse_pkg::ERR_OVER);
                        rsp_value_in  = top_view;
                        rsp_status_in = err_in;
                     end else begin
                        ram_we        = (cnt_ff != '0);  // spill old top
                        top_in        = push_val;
                        cnt_in        = cnt_ff + 1'b1;
                        rsp_value_in  = push_val;
                        rsp_status_in = err_ff;
                     end
                  end
                  default: begin
                     if (cnt_ff < pse_pkg::CNT_W'(2)) begin
                        err_in        = flag(err_ff, pse_pkg::ERR_UNDER);
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = top_view;
                        rsp_status_in = err_in;
                     end else begin
                        ram_re   = 1'b1;   // fetch left operand
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_PUSH;
            case (kind_ff)
               pse_pkg::KIND_ADD: res_in = ram_rd + top_ff;
               pse_pkg::KIND_SUB: res_in = ram_rd - top_ff;
               pse_pkg::KIND_MUL: res_in = ram_rd * top_ff;
               default: begin
                  if (top_ff == 32'd0) begin
                     res_in = 32'd0;
                     err_in = flag(err_ff, pse_pkg::ERR_DIV0);
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
            endcase
         end
         S_DIV: begin
            if (div_rsp.done) begin
               res_in   = div_rsp.quotient;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            // two popped, one pushed: net one fewer entry
            top_in        = res_ff;
            cnt_in        = cnt_m1;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = res_ff;
            rsp_status_in = err_ff;
            rsp_done_in   = 1'b0;
            state_in      = S_FETCH;
         end
         default: state_in = S_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FETCH;
         cnt_ff       <= '0;
         err_ff       <= pse_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      top_ff        <= top_in;
      res_ff        <= res_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tlast  = rsp_done_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/postfix_stack_evaluator.sv
// Top level of the postfix expression evaluator: byte classifier, queue and
// stack engine. Depends on pse_pkg, pse_front and pse_back.
`default_nettype none

// Feed a postfix expression one byte per req transaction; every byte gives
// exactly one rsp transaction. Letters and digits push (byte - '0'), '+', '-'
// and '*' pop two and push the 32-bit wrapped result, any other non-zero
// byte divides (truncating toward zero), and a zero byte ends the expression:
// it reports the top of the stack with rsp_tlast set, then empties the stack
// and clears the sticky error. Status on rsp_tuser is the first error of the
// expression (1 underflow, 2 overflow, 3 divide by zero). The stack holds 128
// entries, with the top kept in a register and the rest in a single-port-read
// RAM; no clearing pass is needed after reset. Engine steps per byte: pushes,
// terminators and operators that find fewer than two entries need only the
// fetch step; '+', '-', '*' and a division by zero go through fetch, stack
// RAM read of the left operand and write back; any other division also waits
// between the read and the write back on the 32-step one-bit-per-cycle
// divider. The engine holds while a result waits on rsp_tready. A 4-entry
// queue in front of the stack engine keeps accepting bytes, until it is full,
// while an operator is in progress or a result waits.
module postfix_stack_evaluator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] char_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [31:0] result_value (signed)
   output logic             rsp_tlast,    // done_res
   output logic [1:0]       rsp_tuser     // [1:0] status
);

   logic              deq_valid;
   logic              deq_ready;
   pse_pkg::item_type deq_item;
   logic              deq_fire;

   pse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .deq_valid  (deq_valid),
      .deq_ready  (deq_ready),
      .deq_item   (deq_item)
   );

   pse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .deq_valid  (deq_valid),
      .deq_ready  (deq_ready),
      .deq_item   (deq_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign deq_fire = deq_valid && deq_ready;

   // the engine only starts an item when the result register can take it
   a_fetch_when_free: assert property (@(posedge clock) disable iff (reset)
      deq_fire |-> (!rsp_tvalid || rsp_tready))
      else $error("item dequeued while a result was still pending");

   // a terminator reports on the next cycle with tlast set
   a_end_reports: assert property (@(posedge clock) disable iff (reset)
      (deq_fire && deq_item.kind == pse_pkg::KIND_END) |=>
      (rsp_tvalid && rsp_tlast))
      else $error("terminator did not produce a done result");

   // a push reports on the next cycle without tlast
   a_push_reports: assert property (@(posedge clock) disable iff (reset)
      (deq_fire && deq_item.kind == pse_pkg::KIND_PUSH) |=>
      (rsp_tvalid && !rsp_tlast))
      else $error("push did not produce a result");

endmodule

`default_nettype wire
